>>> hdl/bounded_list_deque_core_macros.svh
// Assertion macros for the bounded list deque core.
`ifndef BOUNDED_LIST_DEQUE_CORE_MACROS_SVH
`define BOUNDED_LIST_DEQUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define BLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hdl/bld_pkg.sv
// Constants, control word type and microprogram of the bounded list deque core.
package bld_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 4;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 5;
  localparam int UPC_W    = 4;
  localparam int AOP_W    = 4;
  localparam int JC_W     = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 4'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd5;
  localparam logic [OP_W-1:0] OP_POP_BACK_N = 4'd6;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 4'd7;
  localparam logic [OP_W-1:0] OP_INS_BLAST  = 4'd8;
  localparam logic [OP_W-1:0] OP_PUSH_SIZE  = 4'd9;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // Datapath actions
  localparam logic [AOP_W-1:0] A_NOP      = 4'd0;
  localparam logic [AOP_W-1:0] A_DISP     = 4'd1;
  localparam logic [AOP_W-1:0] A_RD_PREV  = 4'd2;
  localparam logic [AOP_W-1:0] A_WR_DEC   = 4'd3;
  localparam logic [AOP_W-1:0] A_WR_NEW   = 4'd4;
  localparam logic [AOP_W-1:0] A_RD_NEXT  = 4'd5;
  localparam logic [AOP_W-1:0] A_WR_INC   = 4'd6;
  localparam logic [AOP_W-1:0] A_CNT_DEC  = 4'd7;
  localparam logic [AOP_W-1:0] A_RD_IDX   = 4'd8;
  localparam logic [AOP_W-1:0] A_CMP      = 4'd9;
  localparam logic [AOP_W-1:0] A_RD_FRONT = 4'd10;
  localparam logic [AOP_W-1:0] A_RD_BACK  = 4'd11;
  localparam logic [AOP_W-1:0] A_CAP_BACK = 4'd12;
  localparam logic [AOP_W-1:0] A_ZERO     = 4'd13;

  // Jump conditions
  localparam logic [JC_W-1:0] J_NEXT       = 3'd0;
  localparam logic [JC_W-1:0] J_ALWAYS     = 3'd1;
  localparam logic [JC_W-1:0] J_DISP       = 3'd2;
  localparam logic [JC_W-1:0] J_IDX_EQ_LIM = 3'd3;
  localparam logic [JC_W-1:0] J_NOMATCH    = 3'd4;
  localparam logic [JC_W-1:0] J_EMPTY      = 3'd5;
  localparam logic [JC_W-1:0] J_END        = 3'd6;

  // Step addresses
  localparam logic [UPC_W-1:0] U_DISP     = 4'd0;
  localparam logic [UPC_W-1:0] U_INS_CHK  = 4'd1;
  localparam logic [UPC_W-1:0] U_INS_RD   = 4'd2;
  localparam logic [UPC_W-1:0] U_INS_MV   = 4'd3;
  localparam logic [UPC_W-1:0] U_INS_PUT  = 4'd4;
  localparam logic [UPC_W-1:0] U_DEL_CHK  = 4'd5;
  localparam logic [UPC_W-1:0] U_DEL_RD   = 4'd6;
  localparam logic [UPC_W-1:0] U_DEL_MV   = 4'd7;
  localparam logic [UPC_W-1:0] U_DEL_END  = 4'd8;
  localparam logic [UPC_W-1:0] U_FIND_CHK = 4'd9;
  localparam logic [UPC_W-1:0] U_FIND_RD  = 4'd10;
  localparam logic [UPC_W-1:0] U_FIND_CMP = 4'd11;
  localparam logic [UPC_W-1:0] U_FB       = 4'd12;
  localparam logic [UPC_W-1:0] U_FB_BACK  = 4'd13;
  localparam logic [UPC_W-1:0] U_FB_CAP   = 4'd14;
  localparam logic [UPC_W-1:0] U_FB_ZERO  = 4'd15;

  typedef struct packed {
    logic [AOP_W-1:0] aop;
    logic [JC_W-1:0]  jc;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      U_DISP:     w = '{A_DISP,     J_DISP,       U_DISP};
      U_INS_CHK:  w = '{A_NOP,      J_IDX_EQ_LIM, U_INS_PUT};
      U_INS_RD:   w = '{A_RD_PREV,  J_NEXT,       U_DISP};
      U_INS_MV:   w = '{A_WR_DEC,   J_ALWAYS,     U_INS_CHK};
      U_INS_PUT:  w = '{A_WR_NEW,   J_ALWAYS,     U_FB};
      U_DEL_CHK:  w = '{A_NOP,      J_IDX_EQ_LIM, U_DEL_END};
      U_DEL_RD:   w = '{A_RD_NEXT,  J_NEXT,       U_DISP};
      U_DEL_MV:   w = '{A_WR_INC,   J_ALWAYS,     U_DEL_CHK};
      U_DEL_END:  w = '{A_CNT_DEC,  J_ALWAYS,     U_FB};
      U_FIND_CHK: w = '{A_NOP,      J_IDX_EQ_LIM, U_FB};
      U_FIND_RD:  w = '{A_RD_IDX,   J_NEXT,       U_DISP};
      // a hit falls through into the front/back readout
      U_FIND_CMP: w = '{A_CMP,      J_NOMATCH,    U_FIND_CHK};
      U_FB:       w = '{A_RD_FRONT, J_EMPTY,      U_FB_ZERO};
      U_FB_BACK:  w = '{A_RD_BACK,  J_NEXT,       U_DISP};
      U_FB_CAP:   w = '{A_CAP_BACK, J_END,        U_DISP};
      U_FB_ZERO:  w = '{A_ZERO,     J_END,        U_DISP};
      default:    w = '{A_NOP,      J_END,        U_DISP};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/bounded_list_deque_core.sv
// Bounded list deque core: microcoded sequencer over an entry store with one write and one read port.
//
// An operation is taken when start is high and busy is low; busy then stays high
// until the result, which appears on the out_ ports for one cycle with out_strobe.
// The next operation may be started in that strobe cycle. Every step of the
// microprogram does at most one store read and one store write, so the cost is set
// by the store accesses: clear, pop_back_n, errors and unused opcodes only dispatch
// and read out front and back; a push, pop, remove or insert moves its entries one
// at a time with a check, a read and a write step each; a find checks, reads and
// compares entry by entry until a hit or the end of the list. If the list is empty
// afterwards, the back read is skipped and both values are zero. A find that misses
// on a full list is the worst case. The result cannot be held off by the receiver.
`include "bounded_list_deque_core_macros.svh"

module bounded_list_deque_core import bld_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [ST_W-1:0]          out_status,
  output logic [LEN_W-1:0]         out_length,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_back_value,
  output logic                     out_is_empty,
  output logic                     out_found,
  output logic [LEN_W-1:0]         out_found_position
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic              busy_r,   busy_nxt;
  logic              strobe_r, strobe_nxt;
  logic [UPC_W-1:0]  pc_r,     pc_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [CNT_W-1:0]  idx_r,    idx_nxt;
  logic [CNT_W-1:0]  lim_r,    lim_nxt;
  logic [OP_W-1:0]   op_r,     op_nxt;
  logic [DATA_W-1:0] val_r,    val_nxt;
  logic [DATA_W-1:0] wval_r,   wval_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic              found_r,  found_nxt;
  logic [CNT_W-1:0]  fpos_r,   fpos_nxt;
  logic [DATA_W-1:0] front_r,  front_nxt;
  logic [DATA_W-1:0] back_r,   back_nxt;
  logic [DATA_W-1:0] rdata_r;

  uword_t            uw;
  logic [UPC_W-1:0]  disp_tgt;
  logic              match;
  logic              full;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_ra;

  assign uw    = ucode(pc_r);
  assign match = (rdata_r == val_r);
  assign full  = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    pc_nxt     = pc_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    lim_nxt    = lim_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    wval_nxt   = wval_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    disp_tgt   = U_FB;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = '0;

    if (!busy_r) begin
      pc_nxt = U_DISP;
      if (start) begin
        busy_nxt = 1'b1;
        op_nxt   = in_opcode;
        val_nxt  = in_value;
      end
    end else begin
      case (uw.aop)
        A_DISP: begin
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          fpos_nxt   = '0;
          case (op_r)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_SIZE: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt  = count_r;
                lim_nxt  = (op_r == OP_PUSH_FRONT) ? '0 : count_r;
                wval_nxt = (op_r == OP_PUSH_SIZE) ? DATA_W'(count_r) : val_r;
                disp_tgt = U_INS_CHK;
              end
            end
            OP_INS_BLAST: begin
              if (count_r < CNT_W'(2)) begin
                status_nxt = ST_EMPTY;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt  = count_r;
                lim_nxt  = count_r - 1'b1;
                wval_nxt = val_r;
                disp_tgt = U_INS_CHK;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt  = (op_r == OP_POP_FRONT) ? '0 : count_r - 1'b1;
                lim_nxt  = count_r - 1'b1;
                disp_tgt = U_DEL_CHK;
              end
            end
            OP_REMOVE_AT: begin
              if (val_r[DATA_W-1] || val_r == '0 || val_r > DATA_W'(count_r)) begin
                status_nxt = ST_BADPOS;
              end else begin
                idx_nxt  = CNT_W'(val_r - 1'b1);
                lim_nxt  = count_r - 1'b1;
                disp_tgt = U_DEL_CHK;
              end
            end
            OP_FIND: begin
              idx_nxt  = '0;
              lim_nxt  = count_r;
              disp_tgt = U_FIND_CHK;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_POP_BACK_N: begin
              if (val_r[DATA_W-1]) begin
                status_nxt = ST_BADPOS;
              end else if (val_r >= DATA_W'(count_r)) begin
                count_nxt = '0;
              end else begin
                count_nxt = count_r - CNT_W'(val_r);
              end
            end
            default: ;
          endcase
        end
        A_RD_PREV: begin
          mem_re = 1'b1;
          mem_ra = IDX_W'(idx_r - 1'b1);
        end
        A_WR_DEC: begin
          mem_we  = 1'b1;
          mem_wa  = idx_r[IDX_W-1:0];
          mem_wd  = rdata_r;
          idx_nxt = idx_r - 1'b1;
        end
        A_WR_NEW: begin
          mem_we    = 1'b1;
          mem_wa    = idx_r[IDX_W-1:0];
          mem_wd    = wval_r;
          count_nxt = count_r + 1'b1;
        end
        A_RD_NEXT: begin
          mem_re = 1'b1;
          mem_ra = IDX_W'(idx_r + 1'b1);
        end
        A_WR_INC: begin
          mem_we  = 1'b1;
          mem_wa  = idx_r[IDX_W-1:0];
          mem_wd  = rdata_r;
          idx_nxt = idx_r + 1'b1;
        end
        A_CNT_DEC: begin
          count_nxt = count_r - 1'b1;
        end
        A_RD_IDX: begin
          mem_re = 1'b1;
          mem_ra = idx_r[IDX_W-1:0];
        end
        A_CMP: begin
          idx_nxt = idx_r + 1'b1;
          if (match) begin
            found_nxt = 1'b1;
            fpos_nxt  = idx_r + 1'b1;
          end
        end
        A_RD_FRONT: begin
          mem_re = 1'b1;
          mem_ra = '0;
        end
        A_RD_BACK: begin
          // front word lands from the previous read
          mem_re    = 1'b1;
          mem_ra    = IDX_W'(count_r - 1'b1);
          front_nxt = rdata_r;
        end
        A_CAP_BACK: begin
          back_nxt = rdata_r;
        end
        A_ZERO: begin
          front_nxt = '0;
          back_nxt  = '0;
        end
        default: ;
      endcase

      pc_nxt = pc_r + 1'b1;
      case (uw.jc)
        J_NEXT:       ;
        J_ALWAYS:     pc_nxt = uw.tgt;
        J_DISP:       pc_nxt = disp_tgt;
        J_IDX_EQ_LIM: if (idx_r == lim_r) pc_nxt = uw.tgt;
        J_NOMATCH:    if (!match) pc_nxt = uw.tgt;
        J_EMPTY:      if (count_r == '0) pc_nxt = uw.tgt;
        J_END: begin
          pc_nxt     = U_DISP;
          busy_nxt   = 1'b0;
          strobe_nxt = 1'b1;
        end
        default:      pc_nxt = U_DISP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      pc_r     <= U_DISP;
      count_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
      pc_r     <= pc_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    lim_r    <= lim_nxt;
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    wval_r   <= wval_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign busy               = busy_r;
  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_length         = LEN_W'(count_r);
  assign out_front_value    = $signed(front_r);
  assign out_back_value     = $signed(back_r);
  assign out_is_empty       = (count_r == '0);
  assign out_found          = found_r;
  assign out_found_position = LEN_W'(fpos_r);

  `BLD_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy_r, busy_r && pc_r == U_DISP, "accepted transfer did not start the dispatch step")
  `BLD_ASSERT_IMP(a_strobe_idle, clk, rst_n, strobe_r, !busy_r, "result strobe while still busy")
  `BLD_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `BLD_ASSERT_IMP(a_found_ok, clk, rst_n, strobe_r && found_r, status_r == ST_OK && fpos_r != '0 && op_r == OP_FIND, "find hit with bad status or position")
  `BLD_ASSERT_NXT(a_idle_hold, clk, rst_n, !busy_r && !start, $stable(count_r) && !strobe_r, "state changed while idle")

endmodule

>>> verif/bld_checker.sv
// Checker for the bounded list deque core: models the list, predicts each result and compares.
module bld_checker import bld_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_strobe,
  input  logic [ST_W-1:0]          out_status,
  input  logic [LEN_W-1:0]         out_length,
  input  logic signed [DATA_W-1:0] out_front_value,
  input  logic signed [DATA_W-1:0] out_back_value,
  input  logic                     out_is_empty,
  input  logic                     out_found,
  input  logic [LEN_W-1:0]         out_found_position,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic                     is_empty;
    logic                     found;
    logic [LEN_W-1:0]         found_pos;
  } deque_result_t;

  logic signed [DATA_W-1:0] list_words [CAPACITY];
  int unsigned              list_len;
  deque_result_t            expected_results [$];

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void insert_word(input int unsigned idx, input logic [DATA_W-1:0] w);
    for (int unsigned i = list_len; i > idx; i--)
      list_words[i] = list_words[i-1];
    list_words[idx] = w;
    list_len++;
  endfunction

  function automatic void delete_word(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++)
      list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] v);
    deque_result_t r;
    r.status    = ST_OK;
    r.found     = 1'b0;
    r.found_pos = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_SIZE: begin
        if (list_len >= CAPACITY)
          r.status = ST_FULL;
        else if (op == OP_PUSH_FRONT)
          insert_word(0, v);
        else if (op == OP_PUSH_SIZE)
          insert_word(list_len, DATA_W'(list_len));
        else
          insert_word(list_len, v);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_len == 0)
          r.status = ST_EMPTY;
        else
          delete_word((op == OP_POP_FRONT) ? 0 : list_len - 1);
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < list_len && !r.found; i++) begin
          if (list_words[i] == v) begin
            r.found     = 1'b1;
            r.found_pos = LEN_W'(i + 1);
          end
        end
      end
      OP_CLEAR: list_len = 0;
      OP_POP_BACK_N: begin
        if (v[DATA_W-1])
          r.status = ST_BADPOS;
        else if (v >= list_len)
          list_len = 0;
        else
          list_len = list_len - v;
      end
      OP_REMOVE_AT: begin
        if (v[DATA_W-1] || v == 0 || v > list_len)
          r.status = ST_BADPOS;
        else
          delete_word(v - 1);
      end
      OP_INS_BLAST: begin
        // too few entries wins over full
        if (list_len < 2)
          r.status = ST_EMPTY;
        else if (list_len >= CAPACITY)
          r.status = ST_FULL;
        else
          insert_word(list_len - 1, v);
      end
      default: ;
    endcase
    r.length   = LEN_W'(list_len);
    r.front    = (list_len != 0) ? list_words[0] : '0;
    r.back     = (list_len != 0) ? list_words[list_len-1] : '0;
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t want;
    if (!rst_n) begin
      list_len   = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // predict at transfer so the queue already holds it when its strobe comes
      if (start && !busy)
        expected_results.push_back(apply_deque_op(in_opcode, in_value));
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
          if (out_length !== want.length)
            flag_mismatch("length", DATA_W'(out_length), DATA_W'(want.length));
          if (out_front_value !== want.front)
            flag_mismatch("front_value", out_front_value, want.front);
          if (out_back_value !== want.back)
            flag_mismatch("back_value", out_back_value, want.back);
          if (out_is_empty !== want.is_empty)
            flag_mismatch("is_empty", DATA_W'(out_is_empty), DATA_W'(want.is_empty));
          if (out_found !== want.found)
            flag_mismatch("found", DATA_W'(out_found), DATA_W'(want.found));
          if (out_found_position !== want.found_pos)
            flag_mismatch("found_position", DATA_W'(out_found_position),
                          DATA_W'(want.found_pos));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> verif/tb_top.sv
// Top of the bounded list deque testbench: clock, reset, stimulus and verdict.
module tb_top;
  import bld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_LEN    = 40;
  localparam int DRAIN_EVERY  = 250;
  localparam int UNUSED_SLOT  = 10;
  localparam int SETTLE       = 3 * CAPACITY + 8;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} phase_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          in_opcode;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_strobe;
  logic [ST_W-1:0]          out_status;
  logic [LEN_W-1:0]         out_length;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_back_value;
  logic                     out_is_empty;
  logic                     out_found;
  logic [LEN_W-1:0]         out_found_position;
  int                       fail_count;
  int                       pending;

  // weights per opcode in opcode order, last slot covers the unused opcodes
  int unsigned op_weight [3][11] = '{
    '{14, 14,  6,  6, 14, 1, 4,  6, 10, 10, 3},
    '{ 5,  5, 15, 15, 12, 3, 8, 12,  4,  3, 3},
    '{ 9,  9,  9,  9, 15, 2, 6, 10,  9,  6, 3}
  };
  logic signed [DATA_W-1:0] value_pool [8];

  bounded_list_deque_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_length        (out_length),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_is_empty      (out_is_empty),
    .out_found         (out_found),
    .out_found_position(out_found_position)
  );

  bld_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_length        (out_length),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_is_empty      (out_is_empty),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hold start and the operands until the transfer
  task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
    @(negedge clk);
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start     <= 1'b0;
      in_opcode <= OP_W'($urandom);
      in_value  <= $urandom;
    end
  endtask

  task automatic drain_results();
    idle_gap(1);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    phase_t                   mode;
    bit                       no_idle;
    int unsigned              total;
    int unsigned              pick;
    int                       k;
    int                       gap;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_opcode = OP_PUSH_FRONT;
    in_value  = '0;
    value_pool = '{32'sh0, -32'sh1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh1,
                   $urandom, $urandom, $urandom};
    mode    = MODE_MIXED;
    no_idle = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty-list errors, then a short list with the field extremes
    send_op(OP_POP_FRONT, 32'sh0);
    send_op(OP_POP_BACK, -32'sh1);
    send_op(OP_FIND, 32'sh0);
    send_op(OP_REMOVE_AT, 32'sh1);
    send_op(OP_INS_BLAST, 32'sh7);
    send_op(OP_POP_BACK_N, -32'sh1);
    send_op(OP_PUSH_SIZE, 32'sh5a5a_a5a5);
    send_op(OP_INS_BLAST, 32'sh9);
    send_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(OP_PUSH_BACK, 32'sh8000_0000);
    send_op(OP_INS_BLAST, -32'sh1);
    send_op(OP_FIND, 32'sh8000_0000);
    send_op(OP_FIND, 32'sh7fff_ffff);
    send_op(OP_FIND, 32'sh0001_2345);
    send_op(OP_REMOVE_AT, 32'sh0);
    send_op(OP_REMOVE_AT, 32'sh5);
    send_op(OP_REMOVE_AT, -32'sh2);
    send_op(OP_REMOVE_AT, 32'sh2);
    send_op(OP_POP_BACK_N, 32'sh0);
    send_op(OP_POP_BACK_N, 32'sh1);
    send_op(OP_UNUSED_HI, 32'shffff_ffff);
    send_op(OP_POP_BACK_N, 32'sh64);
    send_op(OP_PUSH_BACK, 32'sh0);
    send_op(OP_CLEAR, 32'sh3);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        mode    = phase_t'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (n % DRAIN_EVERY == DRAIN_EVERY / 2)
        drain_results();

      total = 0;
      for (int j = 0; j < $size(op_weight, 2); j++) total += op_weight[mode][j];
      pick = $urandom_range(0, total - 1);
      k = 0;
      while (pick >= op_weight[mode][k]) begin
        pick -= op_weight[mode][k];
        k++;
      end
      if (k == UNUSED_SLOT)
        op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
        op = OP_W'(k);

      if (op == OP_POP_BACK_N || op == OP_REMOVE_AT) begin
        case ($urandom_range(0, 9))
          7:       val = {1'b1, 31'($urandom)};
          8, 9:    val = $urandom;
          default: val = $urandom_range(0, CAPACITY + 1);
        endcase
      end else if ($urandom_range(0, 1) == 1) begin
        val = value_pool[$urandom_range(0, 7)];
      end else begin
        val = $urandom;
      end

      send_op(op, val);

      if (no_idle) begin
        gap = 0;
      end else begin
        case ($urandom_range(0, 9))
          0:          gap = $urandom_range(8, 40);
          1, 2, 3:    gap = $urandom_range(1, 3);
          default:    gap = 0;
        endcase
      end
      idle_gap(gap);
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> bounded_list_deque_core.f
+incdir+hdl
hdl/bld_pkg.sv
hdl/bounded_list_deque_core.sv
verif/bld_checker.sv
verif/tb_top.sv
